// ===== rtl/ght_pkg.sv =====
package ght_pkg;

    localparam int SLOTS_DEF        = 256;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ1,
        S_READ2,
        S_WRITE,
        S_SCAN,
        S_OUT,
        S_CLEAR
    } state_t;

endpackage

// ===== rtl/ght_ram.sv =====
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/generational_handle_table.sv =====
// Steps: an accepted item passes S_READ1, S_READ2 and S_WRITE, where the result is
// registered, then S_OUT; a successful create first adds a free-slot scan (S_SCAN) over
// the valid bitmap, one bit a cycle. One item at a time: the next is accepted only after
// the result is taken. Reads: dense position and last entry first, then the word at the hole.
// Reset: rst_n clears valid bits, live count and the free-slot pointer at once, then a
// pass over every slot zeroes the era memory while s_tready stays low.
module generational_handle_table #(
    parameter int SLOTS        = ght_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], slot_index[9:2], era[17:10], payload[49:18], zero pad
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], handle_slot[9:2], handle_era[17:10], dense_position[25:18],
    // payload_out[57:26], live_entries[66:58], zero pad
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;
    localparam int PW = PAYLOAD_BITS;

    ght_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    live_reg, free_reg, scan_reg;

    logic [1:0]  mode_reg;
    logic [7:0]  sidx_reg, era_reg;
    logic [7:0]  era_cur_reg;
    logic [PW-1:0] pay_reg;
    logic [71:0] out_reg, out_next;
    logic        ok_reg;

    // slot_to_dense, dense_owner, dense_word, slot eras
    logic          s2d_we, own_we, word_we, gen_we;
    logic [AW-1:0] s2d_wa, s2d_ra, own_wa, own_ra, word_wa, word_ra, gen_wa, gen_ra;
    logic [AW-1:0] s2d_wd, s2d_rd, own_wd, own_rd;
    logic [PW-1:0] word_wd, word_rd;
    logic [7:0]    gen_wd, gen_rd;
    logic [AW-1:0] pos_reg, last_reg;
    logic [PW-1:0] lastword_reg;

    ght_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_s2d (.clk, .we(s2d_we), .waddr(s2d_wa),
        .wdata(s2d_wd), .raddr(s2d_ra), .rdata(s2d_rd));
    ght_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_own (.clk, .we(own_we), .waddr(own_wa),
        .wdata(own_wd), .raddr(own_ra), .rdata(own_rd));
    ght_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_word (.clk, .we(word_we), .waddr(word_wa),
        .wdata(word_wd), .raddr(word_ra), .rdata(word_rd));
    ght_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_gen (.clk, .we(gen_we), .waddr(gen_wa),
        .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_rd));

    logic [AW-1:0] in_slot, free_slot;
    logic          slot_in_range, hok;
    logic [AW-1:0] last_c;

    assign s_tready  = (state_reg == ght_pkg::S_IDLE);
    assign m_tvalid  = (state_reg == ght_pkg::S_OUT);
    assign m_tdata   = out_reg;
    assign in_slot   = AW'(sidx_reg);
    assign free_slot = free_reg[AW-1:0];
    assign slot_in_range = (32'(sidx_reg) < 32'(SLOTS));
    assign hok       = slot_in_range && valid_reg[in_slot] && (gen_rd == era_reg);
    assign last_c    = AW'(live_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ght_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s2d_we = 1'b0; own_we = 1'b0; word_we = 1'b0; gen_we = 1'b0;
        s2d_wa = in_slot; s2d_wd = pos_reg; s2d_ra = in_slot;
        own_wa = pos_reg; own_wd = in_slot; own_ra = last_c;
        word_wa = pos_reg; word_wd = pay_reg; word_ra = s2d_rd;
        gen_wa = in_slot; gen_wd = era_cur_reg + 8'd1; gen_ra = in_slot;
        unique case (state_reg)
            ght_pkg::S_CLEAR:
            begin
                gen_we = 1'b1;
                gen_wa = scan_reg[AW-1:0];
                gen_wd = 8'd0;
                if (scan_reg == CW'(SLOTS - 1))
                begin
                    state_next = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_IDLE:
            begin
                // era of the handle slot, or of the free slot for a create
                gen_ra = (s_tdata[1:0] == ght_pkg::MODE_CREATE) ? free_slot
                                                                : AW'(s_tdata[9:2]);
                if (s_tvalid)
                begin
                    state_next = ght_pkg::S_READ1;
                end
            end
            ght_pkg::S_READ1:
            begin
                // slot_to_dense read in flight; also read the last owner and word
                word_ra = last_c;
                state_next = ght_pkg::S_READ2;
            end
            ght_pkg::S_READ2:
            begin
                // s2d_rd valid: read the word at the hole
                word_ra = s2d_rd;
                state_next = ght_pkg::S_WRITE;
            end
            ght_pkg::S_WRITE:
            begin
                state_next = ght_pkg::S_OUT;
                if (ok_reg)
                begin
                    unique case (mode_reg)
                        ght_pkg::MODE_CREATE:
                        begin
                            word_we = 1'b1; own_we = 1'b1; s2d_we = 1'b1;
                            word_wa = AW'(live_reg); own_wa = AW'(live_reg);
                            s2d_wa = free_slot; s2d_wd = AW'(live_reg); own_wd = free_slot;
                            state_next = ght_pkg::S_SCAN;
                        end
                        ght_pkg::MODE_UPDATE:
                        begin
                            word_we = 1'b1;
                        end
                        ght_pkg::MODE_REMOVE:
                        begin
                            gen_we = 1'b1;
                            if (pos_reg != last_reg)
                            begin
                                word_we = 1'b1; own_we = 1'b1; s2d_we = 1'b1;
                                word_wd = lastword_reg; own_wd = own_rd;
                                s2d_wa = own_rd;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ght_pkg::S_SCAN:
            begin
                if (scan_reg >= CW'(SLOTS) || !valid_reg[scan_reg[AW-1:0]])
                begin
                    state_next = ght_pkg::S_OUT;
                end
            end
            ght_pkg::S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ght_pkg::S_IDLE;
                end
            end
            default: state_next = ght_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        out_next[9:2]   = sidx_reg;
        out_next[17:10] = era_reg;
        out_next[66:58] = 9'(live_reg);
        if (mode_reg == ght_pkg::MODE_CREATE)
        begin
            if (ok_reg)
            begin
                out_next[1:0]   = ght_pkg::ST_OK;
                out_next[9:2]   = 8'(free_slot);
                out_next[17:10] = era_cur_reg;
                out_next[25:18] = 8'(live_reg);
                out_next[66:58] = 9'(live_reg + CW'(1));
            end
            else
            begin
                out_next[1:0]  = ght_pkg::ST_FULL;
                out_next[17:2] = 16'd0;
            end
        end
        else if (!ok_reg)
        begin
            out_next[1:0] = ght_pkg::ST_BAD;
        end
        else
        begin
            out_next[1:0]   = ght_pkg::ST_OK;
            out_next[25:18] = 8'(pos_reg);
            if (mode_reg == ght_pkg::MODE_LOOKUP)
            begin
                out_next[57:26] = 32'(word_rd);
            end
            if (mode_reg == ght_pkg::MODE_REMOVE && live_reg != '0)
            begin
                out_next[66:58] = 9'(live_reg - CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            live_reg <= '0;
            free_reg <= '0;
            scan_reg <= '0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ght_pkg::S_CLEAR:
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
                ght_pkg::S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg <= s_tdata[1:0];
                        sidx_reg <= s_tdata[9:2];
                        era_reg  <= s_tdata[17:10];
                        pay_reg  <= PW'(s_tdata[49:18]);
                    end
                end
                ght_pkg::S_READ1:
                begin
                    last_reg    <= last_c;
                    era_cur_reg <= gen_rd;
                    if (mode_reg == ght_pkg::MODE_CREATE)
                    begin
                        ok_reg <= (live_reg < CW'(SLOTS)) && (free_reg < CW'(SLOTS))
                                  && !valid_reg[free_slot];
                    end
                    else
                    begin
                        ok_reg <= hok;
                    end
                end
                ght_pkg::S_READ2:
                begin
                    pos_reg      <= s2d_rd;
                    lastword_reg <= word_rd;
                end
                ght_pkg::S_WRITE:
                begin
                    out_reg <= out_next;
                    if (ok_reg && mode_reg == ght_pkg::MODE_CREATE)
                    begin
                        valid_reg[free_slot] <= 1'b1;
                        live_reg <= live_reg + CW'(1);
                        scan_reg <= free_reg;
                    end
                    if (ok_reg && mode_reg == ght_pkg::MODE_REMOVE)
                    begin
                        valid_reg[in_slot] <= 1'b0;
                        if (live_reg != '0)
                        begin
                            live_reg <= live_reg - CW'(1);
                        end
                        if (CW'(in_slot) < free_reg)
                        begin
                            free_reg <= CW'(in_slot);
                        end
                    end
                end
                ght_pkg::S_SCAN:
                begin
                    if (scan_reg >= CW'(SLOTS) || !valid_reg[scan_reg[AW-1:0]])
                    begin
                        free_reg <= scan_reg;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // output stays while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(SLOTS))
        else $error("live count overflow");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("accept while result pending");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ght_pkg::ST_FULL |-> m_tdata[25:2] == 24'd0)
        else $error("full result carries a handle");

endmodule
